[src/sjf_pkg.sv]
// Shared types and constants for the shortest-job-first scheduler.
// Used by sjf_cell, sjf_store and shortest_job_first_scheduler_core.
`timescale 1ns / 1ps

package sjf_pkg;

	localparam int QueueDepthDefault = 64;
	localparam int IdWidth           = 8;
	localparam int DurWidth          = 16;
	localparam int TickWidth         = 32;
	localparam int CountOutWidth     = 7;

	typedef struct packed {
		logic                arrival_valid;
		logic [IdWidth-1:0]  job_id;
		logic [DurWidth-1:0] duration;
	} job_t;

	typedef struct packed {
		logic                     start_valid;
		logic [IdWidth-1:0]       started_job;
		logic                     arrival_dropped;
		logic [CountOutWidth-1:0] waiting_count;
	} result_t;

	typedef struct packed {
		logic [IdWidth-1:0]  id;
		logic [DurWidth-1:0] dur;
	} entry_t;

	typedef struct packed {
		logic   ins;
		logic   pop;
		entry_t new_entry;
	} store_ctrl_t;

endpackage

[src/sjf_cell.sv]
// One slot of the sorted waiting store; trades entries with its two neighbors.
// Depends on sjf_pkg.
`timescale 1ns / 1ps

module sjf_cell (
	input  logic                clk,
	input  logic                occ,
	input  sjf_pkg::store_ctrl_t ctrl,
	input  sjf_pkg::entry_t     left_entry,
	input  logic                left_gt,
	input  sjf_pkg::entry_t     right_entry,
	input  logic                right_gt,
	output sjf_pkg::entry_t     entry,
	output logic                gt
);
	import sjf_pkg::*;

	entry_t entry_q;
	entry_t ins_val;
	entry_t shift_val;
	entry_t next_val;

	assign gt = !occ || (entry_q.dur > ctrl.new_entry.dur);

	always_comb begin
		ins_val   = !gt ? entry_q : (!left_gt ? ctrl.new_entry : left_entry);
		shift_val = !right_gt ? right_entry : (!gt ? ctrl.new_entry : entry_q);
		case ({ctrl.ins, ctrl.pop})
			2'b10:   next_val = ins_val;
			2'b01:   next_val = right_entry;
			2'b11:   next_val = shift_val;
			default: next_val = entry_q;
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= next_val;
	end

	assign entry = entry_q;

endmodule

[src/sjf_store.sv]
// Row of sjf_cell slots kept sorted by duration, ties in arrival order.
// Depends on sjf_pkg and sjf_cell.
`timescale 1ns / 1ps

module sjf_store #(
	parameter int QUEUE_DEPTH = sjf_pkg::QueueDepthDefault,
	parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                 clk,
	input  logic [CW-1:0]        count,
	input  sjf_pkg::store_ctrl_t ctrl,
	output sjf_pkg::entry_t      head
);
	import sjf_pkg::*;

	entry_t link_ent [QUEUE_DEPTH+2];
	logic   link_gt  [QUEUE_DEPTH+2];

	assign link_ent[0]             = ctrl.new_entry;
	assign link_gt[0]              = 1'b0;
	assign link_ent[QUEUE_DEPTH+1] = ctrl.new_entry;
	assign link_gt[QUEUE_DEPTH+1]  = 1'b1;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		sjf_cell u_cell (
			.clk         (clk),
			.occ         (count > CW'(i)),
			.ctrl        (ctrl),
			.left_entry  (link_ent[i]),
			.left_gt     (link_gt[i]),
			.right_entry (link_ent[i+2]),
			.right_gt    (link_gt[i+2]),
			.entry       (link_ent[i+1]),
			.gt          (link_gt[i+1])
		);
	end

	assign head = (ctrl.ins && link_gt[1]) ? ctrl.new_entry : link_ent[1];

endmodule

[src/shortest_job_first_scheduler_core.sv]
// Non-preemptive shortest-job-first scheduler: one tick per job transaction.
// The result of each accepted job transaction is registered; ticks advance only while job_stall is low.
// The sorted store inserts and pops in the same cycle along its row of cells.
// Reset clears tick counters, busy flag, waiting count and output valid;
// store slots are read only below the waiting count. Depends on sjf_pkg, sjf_store.
`timescale 1ns / 1ps

module shortest_job_first_scheduler_core #(
	parameter int QUEUE_DEPTH = sjf_pkg::QueueDepthDefault
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_valid,
	output logic             job_stall,
	input  sjf_pkg::job_t    job,
	output logic             result_valid,
	input  logic             result_stall,
	output sjf_pkg::result_t result
);
	import sjf_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [TickWidth-1:0] cur_q;
	logic [TickWidth-1:0] fin_q;
	logic                 busy_q;
	logic [CW-1:0]        count_q;
	result_t              res_q;
	logic                 res_valid_q;

	logic                 acc;
	logic [DurWidth-1:0]  dur_eff;
	logic                 full;
	logic                 imm_start;
	logic                 dropped;
	logic                 ins;
	logic                 busy_mid;
	logic                 pop;
	logic [CW-1:0]        count_next;
	logic [CW+6:0]        count_ext;
	entry_t               head;
	store_ctrl_t          ctrl;
	result_t              res_c;

	assign job_stall = res_valid_q && result_stall;
	assign acc       = job_valid && !job_stall;

	always_comb begin
		dur_eff   = (job.duration == '0) ? DurWidth'(1) : job.duration;
		full      = (count_q == CW'(QUEUE_DEPTH));
		imm_start = job.arrival_valid && !busy_q && (count_q == '0);
		dropped   = job.arrival_valid && !imm_start && full;
		ins       = acc && job.arrival_valid && !imm_start && !full;
		busy_mid  = (busy_q || imm_start) && !(busy_q && fin_q == cur_q);
		pop       = acc && !busy_mid && ((count_q != '0) || ins);
		count_next = count_q + CW'(ins) - CW'(pop);
		count_ext  = {7'd0, count_next};

		ctrl.ins             = ins;
		ctrl.pop             = pop;
		ctrl.new_entry.id    = job.job_id;
		ctrl.new_entry.dur   = dur_eff;

		res_c.start_valid     = imm_start || pop;
		res_c.started_job     = imm_start ? job.job_id : (pop ? head.id : '0);
		res_c.arrival_dropped = dropped;
		res_c.waiting_count   = count_ext[6:0];
	end

	sjf_store #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.CW          (CW)
	) u_store (
		.clk   (clk),
		.count (count_q),
		.ctrl  (ctrl),
		.head  (head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			fin_q       <= '0;
			busy_q      <= 1'b0;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else if (acc) begin
			cur_q       <= cur_q + TickWidth'(1);
			count_q     <= count_next;
			busy_q      <= busy_mid || pop;
			res_valid_q <= 1'b1;
			if (imm_start) begin
				fin_q <= cur_q + TickWidth'(dur_eff);
			end else if (pop) begin
				fin_q <= cur_q + TickWidth'(head.dur);
			end
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_q <= res_c;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("waiting count above store depth");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> count_q == '0)
		else $error("jobs waiting while unit idle");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		acc && dropped |-> full)
		else $error("arrival dropped with room in store");

	a_start_id: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_q.start_valid |-> res_q.started_job == '0)
		else $error("started job nonzero without start");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !ins && !pop |=> $stable(count_q))
		else $error("waiting count moved without insert or pop");

endmodule
